[sv/bdh_pkg.sv]
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types and constants for the button debouncer with hold limit.
// ----------------------------------------------------------------------------
package bdh_pkg;

    localparam int unsigned TIME_W       = 32;
    localparam int unsigned CFG_IDX_W    = 2;

    localparam logic [TIME_W-1:0] DEBOUNCE_TIME_RST = 32'd20;
    localparam logic [TIME_W-1:0] MAX_HOLD_TIME_RST = 32'd60000;

    // register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TIME = 2'd0,
        CFG_MAX_HOLD_TIME = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] debounce_time;
        logic [TIME_W-1:0] max_hold_time;
    } t_cfg;

    // one input sample
    typedef struct packed {
        logic              raw_down;
        logic [TIME_W-1:0] now_time;
    } t_in_word;

    // one result
    typedef struct packed {
        logic              press_pulse;
        logic              release_pulse;
        logic              release_was_forced;
        logic [TIME_W-1:0] last_hold_duration;
        logic              button_down;
        logic [TIME_W-1:0] held_duration;
        logic              locked_out;
    } t_out_word;

endpackage

[sv/bdh_cfg.sv]
// ----------------------------------------------------------------------------
// bdh_cfg
// Configuration register file: debounce time and maximum hold time.
// ----------------------------------------------------------------------------
module bdh_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [bdh_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [bdh_pkg::TIME_W-1:0]    i_wr_data,
    output bdh_pkg::t_cfg                 o_cfg
);

    bdh_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time <= bdh_pkg::DEBOUNCE_TIME_RST;
            r_cfg.max_hold_time <= bdh_pkg::MAX_HOLD_TIME_RST;
        end else if (i_wr_en) begin
            case (i_wr_index)
                bdh_pkg::CFG_DEBOUNCE_TIME: r_cfg.debounce_time <= i_wr_data;
                bdh_pkg::CFG_MAX_HOLD_TIME: r_cfg.max_hold_time <= i_wr_data;
                default: ; // unknown index: write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/bdh_eval.sv]
// ----------------------------------------------------------------------------
// bdh_eval
// Debounce state and the per-sample update; state advances when i_fire is high.
// ----------------------------------------------------------------------------
module bdh_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  bdh_pkg::t_cfg     i_cfg,
    input  bdh_pkg::t_in_word i_word,
    output bdh_pkg::t_out_word o_word
);

    localparam int unsigned W = bdh_pkg::TIME_W;

    logic         r_seen, r_stable, r_forced, r_lockout;
    logic [W-1:0] r_chg_time, r_press_start, r_hold;

    logic         n_seen, n_stable, n_forced, n_lockout;
    logic [W-1:0] n_chg_time, n_press_start, n_hold;

    logic         level, seen_chg, deb_ok, press_p, release_p, force_rel, stable1;
    logic [W-1:0] since_chg, since_press;

    always_comb begin
        // lock-out masks the pin to up; a real release clears it
        n_lockout = r_lockout && i_word.raw_down;
        level     = i_word.raw_down && !r_lockout;

        seen_chg   = (level != r_seen);
        n_seen     = level;
        n_chg_time = seen_chg ? i_word.now_time : r_chg_time;
        since_chg  = seen_chg ? '0 : (i_word.now_time - r_chg_time);

        deb_ok = (r_stable != level) && (since_chg >= i_cfg.debounce_time);

        n_stable      = r_stable;
        n_forced      = r_forced;
        n_press_start = r_press_start;
        n_hold        = r_hold;
        press_p       = 1'b0;
        release_p     = 1'b0;
        since_press   = i_word.now_time - r_press_start;

        if (deb_ok) begin
            n_stable = level;
            n_forced = 1'b0;
            if (level) begin
                n_press_start = i_word.now_time;
                press_p       = 1'b1;
                since_press   = '0;
            end else begin
                release_p = 1'b1;
                n_hold    = since_press;
            end
        end

        stable1   = n_stable;
        force_rel = stable1 && (since_press >= i_cfg.max_hold_time);
        if (force_rel) begin
            n_stable   = 1'b0;
            release_p  = 1'b1;
            n_forced   = 1'b1;
            n_hold     = since_press;
            n_lockout  = 1'b1;
            n_seen     = 1'b0;
            n_chg_time = i_word.now_time;
        end

        o_word.press_pulse        = press_p;
        o_word.release_pulse      = release_p;
        o_word.release_was_forced = n_forced;
        o_word.last_hold_duration = n_hold;
        o_word.button_down        = n_stable;
        o_word.held_duration      = n_stable ? since_press : '0;
        o_word.locked_out         = n_lockout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= 1'b0;
            r_stable      <= 1'b0;
            r_forced      <= 1'b0;
            r_lockout     <= 1'b0;
            r_chg_time    <= '0;
            r_press_start <= '0;
            r_hold        <= '0;
        end else if (i_fire) begin
            r_seen        <= n_seen;
            r_stable      <= n_stable;
            r_forced      <= n_forced;
            r_lockout     <= n_lockout;
            r_chg_time    <= n_chg_time;
            r_press_start <= n_press_start;
            r_hold        <= n_hold;
        end
    end

endmodule

[sv/button_debounce_hold_limit_core.sv]
// ----------------------------------------------------------------------------
// button_debounce_hold_limit_core
// Button debouncer with hold timeout, one sample per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) takes one sample word:
//   raw pin level plus a wrapping millisecond timestamp. Every sample yields
//   exactly one result word on the output channel (o_out_valid / i_out_stall /
//   o_out_word) with press/release pulses, debounced level, hold times and the
//   lock-out flag.
//   Config channel (i_cfg_valid / o_cfg_ready) writes debounce_time (index 0)
//   or max_hold_time (index 1); other indexes are ignored. Write only while
//   the block is idle. o_cfg_ready is always high.
//   Path: an accepted sample goes into the input register, then the update
//   logic feeds the result register that presents the result word.
//   Throughput: one word per cycle unless the output stalls; the path is
//   a 32-bit subtract and compare chain through the state registers, which
//   update once per word.
//   Reset (synchronous, active low): all state cleared, debounce_time = 20,
//   max_hold_time = 60000, both pipeline stages empty.
//   Output stall: the result register holds; the input register still fills,
//   and o_in_stall rises once both stages are occupied.
// ----------------------------------------------------------------------------
module button_debounce_hold_limit_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bdh_pkg::t_in_word             i_in_word,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bdh_pkg::t_out_word            o_out_word,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bdh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdh_pkg::TIME_W-1:0]    i_cfg_data
);

    bdh_pkg::t_cfg      cfg;
    bdh_pkg::t_in_word  r_in_word;
    bdh_pkg::t_out_word r_out_word, eval_word;
    logic               r_in_valid, r_out_valid;
    logic               out_adv, in_adv, fire;

    assign o_cfg_ready = 1'b1;

    bdh_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // result slot frees when empty or being taken
    assign out_adv    = !r_out_valid || !i_out_stall;
    // a held sample moves into the result register (and updates state)
    assign fire       = r_in_valid && out_adv;
    assign in_adv     = !r_in_valid || out_adv;
    assign o_in_stall = !in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    bdh_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cfg   (cfg),
        .i_word  (r_in_word),
        .o_word  (eval_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= eval_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[verif/button_debounce_hold_limit_checker.sv]
// ----------------------------------------------------------------------------
// button_debounce_hold_limit_checker
// Watches the sample, result and config channels of the debouncer, predicts
// every result word and compares it against the one the block delivers.
// ----------------------------------------------------------------------------
module button_debounce_hold_limit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  bdh_pkg::t_in_word             i_in_word,

    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  bdh_pkg::t_out_word            i_out_word,

    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [bdh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdh_pkg::TIME_W-1:0]    i_cfg_data,

    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // local copy of the config and debounce state
    logic [bdh_pkg::TIME_W-1:0] deb_ms;
    logic [bdh_pkg::TIME_W-1:0] hold_limit_ms;
    logic                       seen_lvl;
    logic                       stable_lvl;
    logic [bdh_pkg::TIME_W-1:0] change_ms;
    logic [bdh_pkg::TIME_W-1:0] press_ms;
    logic [bdh_pkg::TIME_W-1:0] last_hold_ms;
    logic                       forced;
    logic                       lock_flag;

    bdh_pkg::t_out_word         results_due[$];
    bdh_pkg::t_out_word         want;
    int                         shown = 0;

    // one sample through the debouncer, returns the result word
    function automatic bdh_pkg::t_out_word debounce_step(input bdh_pkg::t_in_word w);
        bdh_pkg::t_out_word         r;
        logic                       lvl;
        logic [bdh_pkg::TIME_W-1:0] gap;
        r   = '0;
        lvl = w.raw_down;
        if (lock_flag) begin
            // masked to up until the pin is really let go
            if (!lvl) lock_flag = 1'b0;
            lvl = 1'b0;
        end
        if (lvl != seen_lvl) begin
            seen_lvl  = lvl;
            change_ms = w.now_time;
        end
        gap = w.now_time - change_ms;
        if (stable_lvl != seen_lvl && gap >= deb_ms) begin
            stable_lvl = seen_lvl;
            forced     = 1'b0;
            if (stable_lvl) begin
                press_ms      = w.now_time;
                r.press_pulse = 1'b1;
            end else begin
                r.release_pulse = 1'b1;
                last_hold_ms    = w.now_time - press_ms;
            end
        end
        gap = w.now_time - press_ms;
        if (stable_lvl && gap >= hold_limit_ms) begin
            // hold limit hit: forced release and lock-out
            stable_lvl      = 1'b0;
            r.release_pulse = 1'b1;
            forced          = 1'b1;
            last_hold_ms    = gap;
            lock_flag       = 1'b1;
            seen_lvl        = 1'b0;
            change_ms       = w.now_time;
        end
        r.release_was_forced = forced;
        r.last_hold_duration = last_hold_ms;
        r.button_down        = stable_lvl;
        r.held_duration      = stable_lvl ? gap : '0;
        r.locked_out         = lock_flag;
        return r;
    endfunction

    function automatic string fmt_word(input bdh_pkg::t_out_word w);
        return $sformatf("press=%b rel=%b forced=%b last=%0d down=%b held=%0d lock=%b",
                         w.press_pulse, w.release_pulse, w.release_was_forced,
                         w.last_hold_duration, w.button_down, w.held_duration,
                         w.locked_out);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            deb_ms        = bdh_pkg::DEBOUNCE_TIME_RST;
            hold_limit_ms = bdh_pkg::MAX_HOLD_TIME_RST;
            seen_lvl      = 1'b0;
            stable_lvl    = 1'b0;
            change_ms     = '0;
            press_ms      = '0;
            last_hold_ms  = '0;
            forced        = 1'b0;
            lock_flag     = 1'b0;
            o_fail_count  = 0;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    bdh_pkg::CFG_DEBOUNCE_TIME: deb_ms = i_cfg_data;
                    bdh_pkg::CFG_MAX_HOLD_TIME: hold_limit_ms = i_cfg_data;
                    default: ;
                endcase
            end
            // retire before predicting so a word never meets its own prediction
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    o_fail_count++;
                    if (shown < 10)
                        $display("%0t: unexpected result word: %s", $realtime,
                                 fmt_word(i_out_word));
                    shown++;
                end else begin
                    want = results_due.pop_front();
                    if (i_out_word.press_pulse        !== want.press_pulse        ||
                        i_out_word.release_pulse      !== want.release_pulse      ||
                        i_out_word.release_was_forced !== want.release_was_forced ||
                        i_out_word.last_hold_duration !== want.last_hold_duration ||
                        i_out_word.button_down        !== want.button_down        ||
                        i_out_word.held_duration      !== want.held_duration      ||
                        i_out_word.locked_out         !== want.locked_out) begin
                        o_fail_count++;
                        if (shown < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected %s", fmt_word(want));
                            $display("  actual   %s", fmt_word(i_out_word));
                        end
                        shown++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                results_due.push_back(debounce_step(i_in_word));
        end
        o_pending = results_due.size();
    end

endmodule

[verif/button_debounce_hold_limit_core_tb.sv]
// ----------------------------------------------------------------------------
// button_debounce_hold_limit_core_tb
// Drives sample words into the debouncer through several config settings and
// idle patterns; a side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module button_debounce_hold_limit_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // index values past the register list, writes there must be dropped
    localparam logic [bdh_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [bdh_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;
    localparam logic [bdh_pkg::TIME_W-1:0]    TIME_MAX         = '1;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;

    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    bdh_pkg::t_in_word             in_word   = '0;

    logic                          out_valid;
    logic                          out_stall = 1'b0;
    bdh_pkg::t_out_word            out_word;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bdh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bdh_pkg::TIME_W-1:0]    cfg_data  = '0;

    int                            fail_count;
    int                            pending;

    // idle odds in percent, per phase
    int unsigned                   send_idle_pct = 0;
    int unsigned                   recv_stall_pct = 0;

    // random sample generator state
    logic [bdh_pkg::TIME_W-1:0]    ms_now     = '0;
    logic                          target_lvl = 1'b0;
    int unsigned                   run_left   = 0;
    int unsigned                   step_max   = 8;

    button_debounce_hold_limit_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    button_debounce_hold_limit_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // result side backpressure, redrawn every cycle
    initial begin
        forever begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Send one sample word. Entered and left at a falling edge; valid stays
    // high on return so back-to-back words need no extra assignment.
    task automatic send_sample(input logic raw, input logic [bdh_pkg::TIME_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        in_word.raw_down <= raw;
        in_word.now_time <= stamp;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Drain: drop valid, wait until every result word is back, then let the
    // two-stage pipe settle before touching config.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bdh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bdh_pkg::TIME_W-1:0]    val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Press/release runs with contact bounce. Time mostly creeps forward in
    // steps scaled to the debounce window; now and then it repeats, and a
    // few percent of samples jump anywhere (including backwards).
    task automatic random_sample();
        int unsigned roll;
        logic        raw;
        roll = $urandom_range(99);
        if (run_left == 0) begin
            target_lvl = !target_lvl;
            run_left   = $urandom_range(30, 1);
        end
        run_left--;
        if (roll < 4)
            ms_now = $urandom();
        else if (roll >= 14)
            ms_now = ms_now + $urandom_range(step_max, 1);
        raw = ($urandom_range(99) < 15) ? !target_lvl : target_lvl;
        send_sample(raw, ms_now);
    endtask

    initial begin
        logic [bdh_pkg::TIME_W-1:0] deb;
        logic [bdh_pkg::TIME_W-1:0] lim;
        int                         n;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // out-of-range indexes: ignored, so debounce stays at 20 ms
        write_reg(CFG_IDX_SPARE_LO, '0);
        write_reg(CFG_IDX_SPARE_HI, '0);
        send_sample(1'b0, 32'd0);
        send_sample(1'b1, 32'd5);
        send_sample(1'b1, 32'd25);          // press accepted after 20 ms
        send_sample(1'b0, 32'd30);          // bounce
        send_sample(1'b1, 32'd35);
        send_sample(1'b1, 32'd60);
        send_sample(1'b0, 32'd100);
        send_sample(1'b0, 32'd120);         // release, held 95 ms

        // zero debounce: accepted on the same sample
        settle();
        write_reg(bdh_pkg::CFG_DEBOUNCE_TIME, '0);
        send_sample(1'b1, 32'd200);
        send_sample(1'b0, 32'd201);

        // zero hold limit: press and forced release together, then lock-out
        settle();
        write_reg(bdh_pkg::CFG_MAX_HOLD_TIME, '0);
        send_sample(1'b1, 32'd300);
        send_sample(1'b1, 32'd301);         // masked while locked
        send_sample(1'b0, 32'd302);         // real release clears lock

        // forced release after a normal press; letting go gives no 2nd release
        settle();
        write_reg(bdh_pkg::CFG_DEBOUNCE_TIME, 32'd10);
        write_reg(bdh_pkg::CFG_MAX_HOLD_TIME, 32'd100);
        send_sample(1'b1, 32'd400);
        send_sample(1'b1, 32'd410);
        send_sample(1'b1, 32'd510);
        send_sample(1'b1, 32'd520);
        send_sample(1'b0, 32'd530);

        // timestamp wrap across zero
        send_sample(1'b1, 32'hFFFF_FFF8);
        send_sample(1'b1, 32'd2);
        send_sample(1'b0, 32'd5);
        send_sample(1'b0, 32'd15);

        // all-ones debounce, reached only by time stepping back one ms
        settle();
        write_reg(bdh_pkg::CFG_DEBOUNCE_TIME, TIME_MAX);
        send_sample(1'b1, 32'd1000);
        send_sample(1'b1, 32'd999);
        send_sample(1'b1, TIME_MAX);        // held past the limit

        // ---- random part ----
        for (int p = 0; p < 12; p++) begin
            n = 110;
            case (p)
                0: begin
                    deb = bdh_pkg::DEBOUNCE_TIME_RST;
                    lim = bdh_pkg::MAX_HOLD_TIME_RST;
                end
                1: begin deb = '0; lim = '0; n = 45; end
                2: begin deb = $urandom_range(30, 1); lim = $urandom_range(300, 20); end
                3: begin deb = TIME_MAX; lim = TIME_MAX; n = 45; end
                4: begin deb = $urandom_range(10, 1); lim = $urandom_range(60, 1); end
                5: begin deb = '0; lim = TIME_MAX; n = 45; end
                6: begin deb = $urandom_range(40, 10); lim = $urandom_range(400, 100); end
                7: begin deb = TIME_MAX; lim = '0; n = 45; end
                default: begin
                    deb = $urandom_range(40, 1);
                    lim = $urandom_range(300, 5);
                end
            endcase
            settle();
            write_reg(bdh_pkg::CFG_DEBOUNCE_TIME, deb);
            write_reg(bdh_pkg::CFG_MAX_HOLD_TIME, lim);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            step_max = (deb > 1000) ? 8 : deb / 4 + 2;
            repeat (n) random_sample();
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("** button_debounce_hold_limit_core: PASSED **");
        end else begin
            $display("** button_debounce_hold_limit_core: FAILED **");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("** button_debounce_hold_limit_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
sv/bdh_pkg.sv
sv/bdh_cfg.sv
sv/bdh_eval.sv
sv/button_debounce_hold_limit_core.sv
verif/button_debounce_hold_limit_checker.sv
verif/button_debounce_hold_limit_core_tb.sv
